// ===== sv/sha256_byte_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher_defines - assertion macros
// Shared concurrent assertion forms for the hasher.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_HASHER_DEFINES_SVH
`define SHA256_BYTE_HASHER_DEFINES_SVH

// check cons in the cycle after ante
`define SHBH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hasher assertion failed");

// check cons in the same cycle as ante
`define SHBH_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hasher assertion failed");

`endif

// ===== sv/shbh_pkg.sv =====
// ----------------------------------------------------------------------------
// shbh_pkg - shared types and constants
// Action codes, queue item type and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package shbh_pkg;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_ABSORB = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
  } item_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/shbh_front.sv =====
// ----------------------------------------------------------------------------
// shbh_front - input side and item queue
// Accepts items, drops unused action codes and queues the rest.
// ----------------------------------------------------------------------------
module shbh_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  shbh_pkg::item_t in_item_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output shbh_pkg::item_t q_item_o
);

  shbh_pkg::item_t mem_q [shbh_pkg::QDepth];
  logic [shbh_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [shbh_pkg::QPtrW:0]   cnt_q, cnt_d;
  logic push, pop, keep;

  assign in_ready_o = (cnt_q != (shbh_pkg::QPtrW+1)'(shbh_pkg::QDepth));
  assign keep = in_item_i.action inside {shbh_pkg::ACT_BEGIN, shbh_pkg::ACT_ABSORB,
                                         shbh_pkg::ACT_FINISH};
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = (cnt_q != '0);
  assign pop  = q_valid_o && q_ready_i;
  assign q_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{shbh_pkg::QPtrW{1'b0}}, push} - {{shbh_pkg::QPtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule

// ===== sv/shbh_back.sv =====
// ----------------------------------------------------------------------------
// shbh_back - hash engine
// Buffers bytes, pads, runs the 64 rounds and emits the digest words.
// ----------------------------------------------------------------------------
module shbh_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  shbh_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     out_word_o,
  output logic [2:0]      out_index_o,
  output logic            out_last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] AFT_ABS = 2'd0;
  localparam logic [1:0] AFT_PAD = 2'd1;
  localparam logic [1:0] AFT_OUT = 2'd2;

  logic [2:0]        state_q, state_d;
  logic [1:0]        after_q, after_d;
  logic [7:0][31:0]  h_q, h_d;
  logic [7:0][31:0]  v_q, v_d;
  logic [511:0]      win_q, win_d;
  logic [63:0]       cnt_q, cnt_d;
  logic [5:0]        fill_q, fill_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [2:0]        idx_q, idx_d;
  logic [31:0]       w_new, t1, t2;

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_word_o  = h_q[idx_q];
  assign out_index_o = idx_q;
  assign out_last_o  = (idx_q == 3'd7);

  assign w_new = win_q[511:480] + shbh_pkg::small_sig0(win_q[479:448]) +
                 win_q[223:192] + shbh_pkg::small_sig1(win_q[63:32]);
  assign t1 = v_q[7] + shbh_pkg::big_sig1(v_q[4]) +
              ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
              shbh_pkg::round_k(rnd_q) + win_q[511:480];
  assign t2 = shbh_pkg::big_sig0(v_q[0]) +
              ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    h_d     = h_q;
    v_d     = v_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.action)
            shbh_pkg::ACT_BEGIN: begin
              for (int i = 0; i < 8; i++) h_d[i] = shbh_pkg::init_hash(3'(i));
              cnt_d  = '0;
              fill_d = '0;
            end
            shbh_pkg::ACT_ABSORB: begin
              win_d  = {win_q[503:0], q_item_i.data};
              cnt_d  = cnt_q + 64'd8;
              fill_d = fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                v_d = h_q; rnd_d = '0; after_d = AFT_ABS; state_d = ST_COMP;
              end
            end
            shbh_pkg::ACT_FINISH: begin
              win_d  = {win_q[503:0], 8'h80};
              fill_d = fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                v_d = h_q; rnd_d = '0; after_d = AFT_PAD; state_d = ST_COMP;
              end else begin
                state_d = ST_PAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (fill_q == 6'd56) begin
          win_d  = {win_q[447:0], cnt_q};
          fill_d = '0;
          v_d = h_q; rnd_d = '0; after_d = AFT_OUT; state_d = ST_COMP;
        end else begin
          win_d  = {win_q[503:0], 8'h00};
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            v_d = h_q; rnd_d = '0; after_d = AFT_PAD; state_d = ST_COMP;
          end
        end
      end
      ST_COMP: begin
        win_d = {win_q[479:0], w_new};
        v_d   = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = ST_ADD;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        idx_d = '0;
        case (after_q)
          AFT_PAD: state_d = ST_PAD;
          AFT_OUT: state_d = ST_OUT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_d[i] = shbh_pkg::init_hash(3'(i));
            cnt_d   = '0;
            fill_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= AFT_ABS;
      for (int i = 0; i < 8; i++) h_q[i] <= shbh_pkg::init_hash(3'(i));
      cnt_q   <= '0;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      h_q     <= h_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

endmodule

// ===== sv/sha256_byte_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_hasher - byte-stream SHA-256
// Channel  Dir  Content
// s_axis   in   tdata[7:0] data_byte, tuser[1:0] action
// m_axis   out  tdata[31:0] digest_word, tdata[34:32] word_index, tlast last
// Bytes are absorbed while the engine is idle; every 64th byte starts the round loop.
// Finish: pad bytes up to the length field, a round loop per block, 8 words out.
// Up to four items queue in front while the round loop runs.
// Reset loads the initial hash values; an output stall holds the engine.
// ----------------------------------------------------------------------------
`include "sha256_byte_hasher_defines.svh"

module sha256_byte_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);

  shbh_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  index;
  logic        out_fire;

  assign in_item.action = s_axis_tuser;
  assign in_item.data   = s_axis_tdata;

  shbh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  shbh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (word),
    .out_index_o (index),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, index, word};
  assign out_fire     = m_axis_tvalid && m_axis_tready;

  `SHBH_ASSERT_NEXT(a_index_step, out_fire && !m_axis_tlast, m_axis_tvalid && index == $past(index) + 3'd1)
  `SHBH_ASSERT_NEXT(a_gap_after_last, out_fire && m_axis_tlast, !m_axis_tvalid)
  `SHBH_ASSERT_SAME(a_last_is_seventh, m_axis_tvalid && m_axis_tlast, index == 3'd7)

endmodule
